// File: design/hcl_pkg.sv
package hcl_pkg;

    localparam int NOW_W      = 32;
    localparam int WAIT_W     = 16;
    localparam int LEVEL_W    = 5;
    localparam int HUE_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Depth of the step queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_LEVEL  = CFG_IDX_W'(1);

    localparam logic [WAIT_W-1:0]  WAIT_RESET  = WAIT_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(31);

    // Frame layout.
    localparam logic [IDX_W-1:0] IDX_HEADER = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_BLUE   = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_GREEN  = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_RED    = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(11);

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h00;
    localparam logic [2:0]        HEADER_TAG  = 3'b111;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'hFF;

    // Colour conversion constants.
    localparam logic [HUE_W-1:0] HUE_VALUE    = 8'd160;
    localparam logic [HUE_W-1:0] REGION_WIDTH = 8'd43;

    // One queued step: the hue to convert and the level for its header.
    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] level;
    } step_t;

endpackage

// File: design/hcl_front.sv
module hcl_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hcl_pkg::NOW_W-1:0]        s_now_ms,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output hcl_pkg::step_t                   q_push_data
);
    import hcl_pkg::*;

    logic [NOW_W-1:0]   last_step_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [NOW_W-1:0]   elapsed;
    logic [WAIT_W-1:0]  wait_eff;
    logic               do_step;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;

    // A zero interval behaves as one millisecond.
    assign wait_eff = (wait_reg == '0) ? WAIT_W'(1) : wait_reg;
    assign elapsed  = s_now_ms - last_step_reg;
    assign do_step  = elapsed >= NOW_W'(wait_eff);

    assign q_push            = s_valid && s_ready && do_step;
    assign q_push_data.hue   = hue_reg;
    assign q_push_data.level = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_step_reg <= '0;
            hue_reg       <= '0;
            wait_reg      <= WAIT_RESET;
            level_reg     <= LEVEL_RESET;
        end else begin
            if (q_push) begin
                last_step_reg <= s_now_ms;
                hue_reg       <= hue_reg + HUE_W'(1);
            end
            if (cfg_valid) begin
                if (cfg_index == REG_WAIT_INTERVAL) begin
                    wait_reg <= cfg_data[WAIT_W-1:0];
                end else if (cfg_index == REG_GLOBAL_LEVEL) begin
                    level_reg <= cfg_data[LEVEL_W-1:0];
                end
            end
        end
    end

endmodule

// File: design/hcl_queue.sv
module hcl_queue #(
    parameter int DEPTH = hcl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hcl_pkg::step_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output hcl_pkg::step_t pop_data
);
    import hcl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    step_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/hcl_back.sv
module hcl_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  hcl_pkg::step_t               q_data,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hcl_pkg::BYTE_W-1:0]   m_frame_byte,
    output logic [hcl_pkg::IDX_W-1:0]    m_byte_index,
    output logic                         m_last_of_frame
);
    import hcl_pkg::*;

    logic               busy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [BYTE_W-1:0]  red_reg, green_reg, blue_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic [2:0]         region;
    logic [HUE_W-1:0]   base;
    logic [5:0]         offset;
    logic [HUE_W-1:0]   rem;
    logic [15:0]        q_prod, t_prod;
    logic [BYTE_W-1:0]  q_val, t_val;
    logic [BYTE_W-1:0]  red_next, green_next, blue_next;
    logic               last_taken;

    // Integer HSV at full saturation: the hue falls in one of six regions,
    // the first five 43 wide and the last 41 wide, and the offset inside the region sets the ramp.
    always_comb begin
        priority if (q_data.hue < 8'd43)  region = 3'd0;
        else if     (q_data.hue < 8'd86)  region = 3'd1;
        else if     (q_data.hue < 8'd129) region = 3'd2;
        else if     (q_data.hue < 8'd172) region = 3'd3;
        else if     (q_data.hue < 8'd215) region = 3'd4;
        else                              region = 3'd5;
        base   = 8'(REGION_WIDTH * region);
        offset = 6'(q_data.hue - base);
        rem    = 8'(offset) * 8'd6;
        q_prod = 16'(HUE_VALUE) * 16'(8'hFF - rem);
        t_prod = 16'(HUE_VALUE) * 16'(rem);
        q_val  = q_prod[15:8];
        t_val  = t_prod[15:8];
        unique case (region)
            3'd0: begin
                red_next = HUE_VALUE; green_next = t_val;     blue_next = '0;
            end
            3'd1: begin
                red_next = q_val;     green_next = HUE_VALUE; blue_next = '0;
            end
            3'd2: begin
                red_next = '0;        green_next = HUE_VALUE; blue_next = t_val;
            end
            3'd3: begin
                red_next = '0;        green_next = q_val;     blue_next = HUE_VALUE;
            end
            3'd4: begin
                red_next = t_val;     green_next = '0;        blue_next = HUE_VALUE;
            end
            default: begin
                red_next = HUE_VALUE; green_next = '0;        blue_next = q_val;
            end
        endcase
    end

    assign last_taken = busy_reg && m_ready && (idx_reg == IDX_LAST);
    assign q_pop      = q_valid && (!busy_reg || last_taken);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (last_taken) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && m_ready) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            level_reg <= q_data.level;
        end
    end

    always_comb begin
        priority if (idx_reg < IDX_HEADER) m_frame_byte = START_BYTE;
        else if (idx_reg == IDX_HEADER)    m_frame_byte = {HEADER_TAG, level_reg};
        else if (idx_reg == IDX_BLUE)      m_frame_byte = blue_reg;
        else if (idx_reg == IDX_GREEN)     m_frame_byte = green_reg;
        else if (idx_reg == IDX_RED)       m_frame_byte = red_reg;
        else                               m_frame_byte = END_BYTE;
    end

    assign m_valid         = busy_reg;
    assign m_byte_index    = idx_reg;
    assign m_last_of_frame = idx_reg == IDX_LAST;

endmodule

// File: design/hue_cycle_led_frame_driver.sv
// A stepping word is written into the queue and then taken into the serialiser registers,
// from which it yields twelve words, one per cycle while m_ready is high; the serialiser
// takes the next step as a frame ends. Words are taken every cycle while the queue has room.
// Reset (aresetn low, synchronous): queue and serialiser empty, hue and stored time
// zero, wait interval one, global level 31.
module hue_cycle_led_frame_driver #(
    parameter int QUEUE_DEPTH = hcl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Time stamp input channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hcl_pkg::NOW_W-1:0]        s_now_ms,
    // Frame byte output channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hcl_pkg::BYTE_W-1:0]       m_frame_byte,
    output logic [hcl_pkg::IDX_W-1:0]        m_byte_index,
    output logic                             m_last_of_frame,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hcl_pkg::*;

    // The front end compares the elapsed time against the interval and,
    // on a step, queues the current hue with the global level. It keeps
    // accepting words as long as the queue has room.
    step_t push_data;
    step_t pop_data;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;

    hcl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_now_ms    (s_now_ms),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (push_data)
    );

    // The queue decouples the decision from the frame serialiser.
    hcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    // The back end converts the hue to colour as it takes an entry and
    // then sends the frame a word at a time. It takes the next entry in
    // the same cycle as the last word of a frame leaves, so frames run
    // back to back.
    hcl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_data          (pop_data),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_byte_index    (m_byte_index),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

// File: design/hcl_checker.sv
module hcl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [hcl_pkg::BYTE_W-1:0]     m_frame_byte,
    input logic [hcl_pkg::IDX_W-1:0]      m_byte_index,
    input logic                           m_last_of_frame
);
    import hcl_pkg::*;

    // A stalled word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte)
            && $stable(m_byte_index))
        else $error("stalled frame word changed");

    // Within a frame the words follow without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_frame |=>
            m_valid && (m_byte_index == $past(m_byte_index) + IDX_W'(1)))
        else $error("frame interrupted or out of order");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_frame == (m_byte_index == IDX_LAST)))
        else $error("last flag does not match final index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_byte_index > IDX_RED) |-> (m_frame_byte == END_BYTE))
        else $error("end frame word is wrong");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_byte_index == IDX_HEADER) |-> (m_frame_byte[7:5] == HEADER_TAG))
        else $error("header word lacks its tag bits");

endmodule

bind hue_cycle_led_frame_driver hcl_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_byte    (m_frame_byte),
    .m_byte_index    (m_byte_index),
    .m_last_of_frame (m_last_of_frame)
);
